[rtl/core/clalu_pkg.sv]
// ----------------------------------------------------------------------------
// clalu_pkg
// Shared types and constants of the constant lattice ALU pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package clalu_pkg;

   localparam int ValueBits = 32;
   localparam int DivStages = ValueBits / 2;

   // Lattice kinds.
   localparam logic [1:0] KIND_BOT = 2'd0;
   localparam logic [1:0] KIND_CON = 2'd1;
   localparam logic [1:0] KIND_TOP = 2'd2;

   // Commands.
   localparam logic [4:0] CMD_NOT  = 5'd0;
   localparam logic [4:0] CMD_OR   = 5'd1;
   localparam logic [4:0] CMD_AND  = 5'd2;
   localparam logic [4:0] CMD_EQ   = 5'd3;
   localparam logic [4:0] CMD_NE   = 5'd4;
   localparam logic [4:0] CMD_LT   = 5'd5;
   localparam logic [4:0] CMD_LE   = 5'd6;
   localparam logic [4:0] CMD_GE   = 5'd7;
   localparam logic [4:0] CMD_GT   = 5'd8;
   localparam logic [4:0] CMD_BOR  = 5'd9;
   localparam logic [4:0] CMD_BXOR = 5'd10;
   localparam logic [4:0] CMD_BAND = 5'd11;
   localparam logic [4:0] CMD_BNOT = 5'd12;
   localparam logic [4:0] CMD_NEG  = 5'd13;
   localparam logic [4:0] CMD_ADD  = 5'd14;
   localparam logic [4:0] CMD_SUB  = 5'd15;
   localparam logic [4:0] CMD_MUL  = 5'd16;
   localparam logic [4:0] CMD_DIV  = 5'd17;
   localparam logic [4:0] CMD_MOD  = 5'd18;

   // What the later stages still have to do with an item.
   typedef enum logic [1:0] {
      SEL_DONE,
      SEL_MUL,
      SEL_DIV,
      SEL_MOD
   } sel_type;

   // Payload that travels down the pipeline with each item.
   typedef struct packed {
      logic [1:0]           kind;
      logic [ValueBits-1:0] value;
      logic                 fault;
      sel_type              sel;
      logic [ValueBits-1:0] na;    // multiplicand, or dividend then quotient
      logic [ValueBits-1:0] nb;    // multiplier, or divisor magnitude
      logic [ValueBits-1:0] rem;   // partial remainder
      logic                 negq;
      logic                 negr;
   } stage_type;

endpackage

`default_nettype wire

[rtl/core/const_lattice_alu_top.sv]
// ----------------------------------------------------------------------------
// const_lattice_alu_top
// Tagged ALU over a constant-propagation lattice, fully pipelined.
// ----------------------------------------------------------------------------
// Usage: items enter on the req_ stream and one result item leaves on the
// rsp_ stream for each of them, in the same order. There are no registers
// to program.
// From acceptance to rsp_tvalid an item passes one decode stage,
// one multiplier stage, sixteen divider stages of two quotient bits each
// and the output register. Every operation takes the same path, so one
// item can be accepted per cycle while the output does not stall.
// The pipeline advances as a whole whenever the output register is empty
// or is being taken, so req_tready follows rsp_tready while the output
// holds a result; a stall freezes every stage and nothing is lost.
// Reset (synchronous, active high) empties the pipeline; no item is in
// flight afterwards. Division by zero and the overflow of the minimum
// value divided by minus one return top with the fault bit set.
// ----------------------------------------------------------------------------
`default_nettype none

module const_lattice_alu_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // command[4:0], a_kind[6:5], a_value[38:7], b_kind[40:39],
   // b_value[72:41], zero fill up to bit 79
   input  wire logic [79:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // r_kind[1:0], r_value[33:2], fault[34], zero fill up to bit 39
   output logic [39:0]      rsp_tdata
);

   localparam int NumDiv = clalu_pkg::DivStages;

   logic                 en;
   logic                 v_dec, v_mul;
   clalu_pkg::stage_type s_dec, s_mul;
   logic                 v_div [NumDiv+1];
   clalu_pkg::stage_type s_div [NumDiv+1];

   logic                 valid_ff;
   logic [1:0]           kind_ff, kind_in;
   logic [31:0]          value_ff, value_in;
   logic                 fault_ff;

   // The whole pipeline moves when the output register can take an item.
   assign en         = !valid_ff || rsp_tready;
   assign req_tready = en;

   clalu_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .command   (req_tdata[4:0]),
      .a_kind    (req_tdata[6:5]),
      .a_value   (req_tdata[38:7]),
      .b_kind    (req_tdata[40:39]),
      .b_value   (req_tdata[72:41]),
      .out_valid (v_dec),
      .out_stage (s_dec)
   );

   clalu_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v_dec),
      .in_stage  (s_dec),
      .out_valid (v_mul),
      .out_stage (s_mul)
   );

   assign v_div[0] = v_mul;
   assign s_div[0] = s_mul;

   // Chain of divider stages.
   for (genvar i = 0; i < NumDiv; i++) begin : g_div
      clalu_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (v_div[i]),
         .in_stage  (s_div[i]),
         .out_valid (v_div[i+1]),
         .out_stage (s_div[i+1])
      );
   end

   // Sign correction of quotient and remainder.
   always_comb begin
      kind_in  = s_div[NumDiv].kind;
      value_in = s_div[NumDiv].value;
      case (s_div[NumDiv].sel)
         clalu_pkg::SEL_DIV: begin
            kind_in  = clalu_pkg::KIND_CON;
            value_in = s_div[NumDiv].negq ? (32'd0 - s_div[NumDiv].na)
                                          : s_div[NumDiv].na;
         end
         clalu_pkg::SEL_MOD: begin
            kind_in  = clalu_pkg::KIND_CON;
            value_in = s_div[NumDiv].negr ? (32'd0 - s_div[NumDiv].rem)
                                          : s_div[NumDiv].rem;
         end
         default: begin
            kind_in  = s_div[NumDiv].kind;
            value_in = s_div[NumDiv].value;
         end
      endcase
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= v_div[NumDiv];
      end
      if (en) begin
         kind_ff  <= kind_in;
         value_ff <= value_in;
         fault_ff <= s_div[NumDiv].fault;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'd0, fault_ff, value_ff, kind_ff};

endmodule

`default_nettype wire

[rtl/core/clalu_decode.sv]
// ----------------------------------------------------------------------------
// clalu_decode
// First stage: applies the lattice rules and the operations that need no later stage.
// ----------------------------------------------------------------------------
`default_nettype none

module clalu_decode (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire logic [4:0]           command,
   input  wire logic [1:0]           a_kind,
   input  wire logic [31:0]          a_value,
   input  wire logic [1:0]           b_kind,
   input  wire logic [31:0]          b_value,
   output logic                      out_valid,
   output clalu_pkg::stage_type      out_stage
);

   localparam logic [31:0] MinVal = {1'b1, 31'd0};

   logic                 valid_ff;
   clalu_pkg::stage_type stage_ff, stage_in;

   logic [1:0]  ak, bk;
   logic        a_top, b_top, a_bot, b_bot, a_con, b_con;
   logic        a_true, b_true, a_false, b_false;
   logic        lt_ab, lt_ba;
   logic [1:0]  bin_kind;
   logic [31:0] bin_val;
   logic [31:0] bin_op;
   logic        both_con;

   // Operand kinds, with code three taken as top.
   always_comb begin
      ak = (a_kind == 2'd3) ? clalu_pkg::KIND_TOP : a_kind;
      bk = (b_kind == 2'd3) ? clalu_pkg::KIND_TOP : b_kind;
      a_top = ak == clalu_pkg::KIND_TOP;
      b_top = bk == clalu_pkg::KIND_TOP;
      a_bot = ak == clalu_pkg::KIND_BOT;
      b_bot = bk == clalu_pkg::KIND_BOT;
      a_con = ak == clalu_pkg::KIND_CON;
      b_con = bk == clalu_pkg::KIND_CON;
      a_true  = a_con && (a_value != 32'd0);
      b_true  = b_con && (b_value != 32'd0);
      a_false = a_con && (a_value == 32'd0);
      b_false = b_con && (b_value == 32'd0);
      lt_ab = $signed(a_value) < $signed(b_value);
      lt_ba = $signed(b_value) < $signed(a_value);
      both_con = a_con && b_con;
   end

   // Value of a binary command on two constants.
   always_comb begin
      case (command)
         clalu_pkg::CMD_EQ, clalu_pkg::CMD_NE: bin_op = {31'd0, a_value == b_value};
         clalu_pkg::CMD_LT:   bin_op = {31'd0, lt_ab};
         clalu_pkg::CMD_LE:   bin_op = {31'd0, !lt_ba};
         clalu_pkg::CMD_GE:   bin_op = {31'd0, !lt_ab};
         clalu_pkg::CMD_GT:   bin_op = {31'd0, lt_ba};
         clalu_pkg::CMD_BOR:  bin_op = a_value | b_value;
         clalu_pkg::CMD_BXOR: bin_op = a_value ^ b_value;
         clalu_pkg::CMD_BAND: bin_op = a_value & b_value;
         clalu_pkg::CMD_ADD:  bin_op = a_value + b_value;
         clalu_pkg::CMD_SUB:  bin_op = a_value - b_value;
         default:             bin_op = 32'd0;
      endcase
   end

   // Common rules of the binary commands: top absorbs, bottom is identity.
   always_comb begin
      if (a_top || b_top) begin
         bin_kind = clalu_pkg::KIND_TOP;
         bin_val  = 32'd0;
      end else if (a_bot) begin
         bin_kind = bk;
         bin_val  = b_con ? b_value : 32'd0;
      end else if (b_bot) begin
         bin_kind = ak;
         bin_val  = a_value;
      end else begin
         bin_kind = clalu_pkg::KIND_CON;
         bin_val  = bin_op;
      end
   end

   // Result selection per command.
   always_comb begin
      stage_in       = '0;
      stage_in.sel   = clalu_pkg::SEL_DONE;
      stage_in.kind  = clalu_pkg::KIND_TOP;
      stage_in.value = 32'd0;
      stage_in.fault = 1'b0;
      case (command)
         clalu_pkg::CMD_NOT: begin
            stage_in.kind  = ak;
            stage_in.value = a_con ? {31'd0, a_value == 32'd0} : 32'd0;
         end
         clalu_pkg::CMD_OR: begin
            if (a_top || b_top) begin
               stage_in.kind  = (a_true || b_true) ? clalu_pkg::KIND_CON
                                                   : clalu_pkg::KIND_TOP;
               stage_in.value = {31'd0, a_true || b_true};
            end else if (a_bot) begin
               stage_in.kind  = bk;
               stage_in.value = b_con ? b_value : 32'd0;
            end else if (b_bot) begin
               stage_in.kind  = ak;
               stage_in.value = a_value;
            end else begin
               stage_in.kind  = clalu_pkg::KIND_CON;
               stage_in.value = {31'd0, a_true || b_true};
            end
         end
         clalu_pkg::CMD_AND: begin
            if (a_top || b_top) begin
               stage_in.kind  = (a_false || b_false) ? clalu_pkg::KIND_CON
                                                     : clalu_pkg::KIND_TOP;
               stage_in.value = 32'd0;
            end else if (a_bot) begin
               stage_in.kind  = bk;
               stage_in.value = b_con ? b_value : 32'd0;
            end else if (b_bot) begin
               stage_in.kind  = ak;
               stage_in.value = a_value;
            end else begin
               stage_in.kind  = clalu_pkg::KIND_CON;
               stage_in.value = {31'd0, a_true && b_true};
            end
         end
         clalu_pkg::CMD_NE: begin
            stage_in.kind  = bin_kind;
            stage_in.value = (bin_kind == clalu_pkg::KIND_CON) ?
                             {31'd0, bin_val == 32'd0} : 32'd0;
         end
         clalu_pkg::CMD_EQ, clalu_pkg::CMD_LT, clalu_pkg::CMD_LE,
         clalu_pkg::CMD_GE, clalu_pkg::CMD_GT, clalu_pkg::CMD_BOR,
         clalu_pkg::CMD_BXOR, clalu_pkg::CMD_BAND, clalu_pkg::CMD_ADD,
         clalu_pkg::CMD_SUB: begin
            stage_in.kind  = bin_kind;
            stage_in.value = bin_val;
         end
         clalu_pkg::CMD_BNOT: begin
            stage_in.kind  = ak;
            stage_in.value = a_con ? ~a_value : 32'd0;
         end
         clalu_pkg::CMD_NEG: begin
            stage_in.kind  = ak;
            stage_in.value = a_con ? (32'd0 - a_value) : 32'd0;
         end
         clalu_pkg::CMD_MUL: begin
            stage_in.kind  = bin_kind;
            stage_in.value = bin_val;
            if (both_con) begin
               stage_in.sel = clalu_pkg::SEL_MUL;
               stage_in.na  = a_value;
               stage_in.nb  = b_value;
            end
         end
         clalu_pkg::CMD_DIV, clalu_pkg::CMD_MOD: begin
            stage_in.kind  = bin_kind;
            stage_in.value = bin_val;
            if (both_con) begin
               if ((b_value == 32'd0) || ((a_value == MinVal) && (b_value == '1))) begin
                  stage_in.kind  = clalu_pkg::KIND_TOP;
                  stage_in.value = 32'd0;
                  stage_in.fault = 1'b1;
               end else begin
                  stage_in.sel  = (command == clalu_pkg::CMD_DIV) ?
                                  clalu_pkg::SEL_DIV : clalu_pkg::SEL_MOD;
                  stage_in.na   = a_value[31] ? (32'd0 - a_value) : a_value;
                  stage_in.nb   = b_value[31] ? (32'd0 - b_value) : b_value;
                  stage_in.negq = a_value[31] ^ b_value[31];
                  stage_in.negr = a_value[31];
               end
            end
         end
         default: begin
            stage_in.kind = clalu_pkg::KIND_TOP;
         end
      endcase
   end

   // Stage registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

`default_nettype wire

[rtl/core/clalu_mul.sv]
// ----------------------------------------------------------------------------
// clalu_mul
// Multiplier stage: forms the low word of the product of two constants.
// ----------------------------------------------------------------------------
`default_nettype none

module clalu_mul (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire clalu_pkg::stage_type in_stage,
   output logic                      out_valid,
   output clalu_pkg::stage_type      out_stage
);

   logic                 valid_ff;
   clalu_pkg::stage_type stage_ff, stage_in;

   // Product replaces the value for multiply items; the rest passes on.
   always_comb begin
      stage_in = in_stage;
      if (in_stage.sel == clalu_pkg::SEL_MUL) begin
         stage_in.value = in_stage.na * in_stage.nb;
         stage_in.sel   = clalu_pkg::SEL_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

`default_nettype wire

[rtl/core/clalu_div_stage.sv]
// ----------------------------------------------------------------------------
// clalu_div_stage
// One divider stage: two restoring steps of an unsigned division.
// ----------------------------------------------------------------------------
`default_nettype none

module clalu_div_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire clalu_pkg::stage_type in_stage,
   output logic                      out_valid,
   output clalu_pkg::stage_type      out_stage
);

   logic                 valid_ff;
   clalu_pkg::stage_type stage_ff, stage_in;
   logic [32:0]          t0, t1;
   logic [31:0]          r0;
   logic [31:0]          n0;
   logic                 q0, q1;

   // Shift in one dividend bit, subtract the divisor where it fits; twice.
   always_comb begin
      stage_in = in_stage;
      t0 = {in_stage.rem, in_stage.na[31]};
      q0 = t0 >= {1'b0, in_stage.nb};
      r0 = q0 ? 32'(t0 - {1'b0, in_stage.nb}) : t0[31:0];
      n0 = {in_stage.na[30:0], q0};
      t1 = {r0, n0[31]};
      q1 = t1 >= {1'b0, in_stage.nb};
      if ((in_stage.sel == clalu_pkg::SEL_DIV) || (in_stage.sel == clalu_pkg::SEL_MOD)) begin
         stage_in.rem = q1 ? 32'(t1 - {1'b0, in_stage.nb}) : t1[31:0];
         stage_in.na  = {n0[30:0], q1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

`default_nettype wire

[test/const_lattice_alu_checker.sv]
// ----------------------------------------------------------------------------
// const_lattice_alu_checker
// Watches both streams of the lattice ALU, predicts each result item from
// the accepted request item and compares them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module const_lattice_alu_checker
   import clalu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [79:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [39:0] rsp_tdata,
   output int               fail_count,
   output int               pending
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] value;
      logic        fault;
   } lattice_result_t;

   lattice_result_t result_queue[$];

   localparam logic [31:0] MinValue = 32'h8000_0000;

   function automatic lattice_result_t make_result(logic [1:0] k, logic [31:0] v);
      lattice_result_t r;
      r.kind  = k;
      r.value = (k == KIND_CON) ? v : 32'd0;
      r.fault = 1'b0;
      return r;
   endfunction

   function automatic lattice_result_t make_bool(logic b);
      return make_result(KIND_CON, {31'd0, b});
   endfunction

   function automatic lattice_result_t logical_not(lattice_result_t x);
      if (x.kind != KIND_CON) return x;
      return make_bool(x.value == 32'd0);
   endfunction

   // Predicts one result item from the fields of a request item.
   function automatic lattice_result_t predict_lattice(logic [79:0] d);
      logic [4:0] cmd;
      lattice_result_t a, b, r;
      logic a_true, a_false, b_true, b_false;
      logic signed [31:0] sa, sb;
      cmd = d[4:0];
      a = make_result((d[6:5] == 2'd3) ? KIND_TOP : d[6:5], d[38:7]);
      b = make_result((d[40:39] == 2'd3) ? KIND_TOP : d[40:39], d[72:41]);
      sa = a.value;
      sb = b.value;
      a_true  = a.kind == KIND_CON && a.value != 0;
      a_false = a.kind == KIND_CON && a.value == 0;
      b_true  = b.kind == KIND_CON && b.value != 0;
      b_false = b.kind == KIND_CON && b.value == 0;
      r = make_result(KIND_TOP, 32'd0);
      case (cmd)
         CMD_NOT: r = logical_not(a);
         CMD_BNOT: r = (a.kind == KIND_CON) ? make_result(KIND_CON, ~a.value) : a;
         CMD_NEG: r = (a.kind == KIND_CON) ? make_result(KIND_CON, -a.value) : a;
         CMD_OR, CMD_AND: begin
            // Short-circuit on a known deciding value beside top.
            if (a.kind == KIND_TOP && b.kind == KIND_TOP) r = make_result(KIND_TOP, 0);
            else if ((a.kind == KIND_TOP && (b_true || b_false)) ||
                     (b.kind == KIND_TOP && (a_true || a_false))) begin
               if (cmd == CMD_OR)
                  r = (a_true || b_true) ? make_bool(1'b1) : make_result(KIND_TOP, 0);
               else
                  r = (a_false || b_false) ? make_bool(1'b0) : make_result(KIND_TOP, 0);
            end
            else if (a.kind == KIND_BOT) r = b;
            else if (b.kind == KIND_BOT) r = a;
            else if (cmd == CMD_OR) r = make_bool(a_true || b_true);
            else r = make_bool(a_true && b_true);
         end
         CMD_EQ, CMD_NE, CMD_LT, CMD_LE, CMD_GE, CMD_GT, CMD_BOR, CMD_BXOR, CMD_BAND,
         CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD: begin
            if (a.kind == KIND_TOP || b.kind == KIND_TOP) r = make_result(KIND_TOP, 0);
            else if (a.kind == KIND_BOT) r = b;
            else if (b.kind == KIND_BOT) r = a;
            else begin
               case (cmd)
                  CMD_EQ, CMD_NE: r = make_bool(sa == sb);
                  CMD_LT: r = make_bool(sa < sb);
                  CMD_LE: r = make_bool(sa <= sb);
                  CMD_GE: r = make_bool(sa >= sb);
                  CMD_GT: r = make_bool(sa > sb);
                  CMD_BOR: r = make_result(KIND_CON, a.value | b.value);
                  CMD_BXOR: r = make_result(KIND_CON, a.value ^ b.value);
                  CMD_BAND: r = make_result(KIND_CON, a.value & b.value);
                  CMD_ADD: r = make_result(KIND_CON, a.value + b.value);
                  CMD_SUB: r = make_result(KIND_CON, a.value - b.value);
                  CMD_MUL: r = make_result(KIND_CON, a.value * b.value);
                  default: begin
                     // Division by zero and the overflow case fault to top.
                     if (sb == 0 || (a.value == MinValue && sb == -1)) begin
                        r = make_result(KIND_TOP, 0);
                        r.fault = 1'b1;
                     end
                     else if (cmd == CMD_DIV) r = make_result(KIND_CON, sa / sb);
                     else r = make_result(KIND_CON, sa % sb);
                  end
               endcase
            end
            // Not-equal inverts whatever equality gave, bottom rule included.
            if (cmd == CMD_NE) r = logical_not(r);
         end
         default: r = make_result(KIND_TOP, 0);
      endcase
      return r;
   endfunction

   assign pending = result_queue.size();

   // Record predictions and compare result items at each accepting edge.
   always @(posedge clock) begin
      lattice_result_t got, want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready) result_queue.push_back(predict_lattice(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            // The stream carries kind lowest, then value, then fault.
            got = {rsp_tdata[1:0], rsp_tdata[33:2], rsp_tdata[34]};
            if (result_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected result item %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = result_queue.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("mismatch: kind %0d/%0d value %h/%h fault %0d/%0d (exp/act)",
                              want.kind, got.kind, want.value, got.value,
                              want.fault, got.fault);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

[test/const_lattice_alu_top_tb.sv]
// ----------------------------------------------------------------------------
// const_lattice_alu_top_tb
// Drives directed and random request items into the lattice ALU with
// random idling on both streams and reports the checker's verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module const_lattice_alu_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import clalu_pkg::*;

   localparam int WatchdogLimit = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   int          fail_count;
   int          pending;
   int          send_idle_pct = 23;
   int          recv_idle_pct = 74;
   int          quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   const_lattice_alu_top u_top (.*);

   const_lattice_alu_checker u_checker (.*);

   // The receiver stalls at random according to the current phase.
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // Watchdog on cycles without any accepted item.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(7))
         0: return 32'd0;
         1: return 32'd1;
         2: return 32'hFFFF_FFFF;
         3: return 32'h8000_0000;
         4: return 32'h7FFF_FFFF;
         5: return $urandom_range(15) - 8;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [1:0] pick_kind();
      int p;
      p = $urandom_range(99);
      if (p < 70) return KIND_CON;
      if (p < 82) return KIND_BOT;
      if (p < 96) return KIND_TOP;
      return 2'd3;
   endfunction

   // Presents one request item and holds it until it is accepted.
   task automatic send_item(logic [4:0] cmd, logic [1:0] ak, logic [31:0] av,
                            logic [1:0] bk, logic [31:0] bv);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, bv, bk, av, ak, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   initial begin
      logic [4:0] cmd;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items: extremes, lattice kinds, short-circuits and faults.
      send_item(CMD_NOT, KIND_CON, 32'd0, KIND_BOT, 0);
      send_item(CMD_NOT, KIND_TOP, 32'd5, KIND_BOT, 0);
      send_item(CMD_OR, KIND_TOP, 0, KIND_CON, 32'd7);
      send_item(CMD_OR, KIND_CON, 0, KIND_TOP, 0);
      send_item(CMD_OR, KIND_BOT, 0, KIND_CON, 32'd9);
      send_item(CMD_AND, KIND_CON, 0, KIND_TOP, 0);
      send_item(CMD_AND, KIND_TOP, 0, KIND_CON, 32'd3);
      send_item(CMD_AND, 2'd3, 0, 2'd3, 0);
      send_item(CMD_EQ, KIND_CON, 32'h8000_0000, KIND_CON, 32'h8000_0000);
      send_item(CMD_NE, KIND_BOT, 0, KIND_CON, 32'd5);
      send_item(CMD_NE, KIND_CON, 32'd1, KIND_CON, 32'd2);
      send_item(CMD_LT, KIND_CON, 32'h8000_0000, KIND_CON, 32'h7FFF_FFFF);
      send_item(CMD_LE, KIND_CON, 32'hFFFF_FFFF, KIND_CON, 32'hFFFF_FFFF);
      send_item(CMD_GE, KIND_CON, 32'h7FFF_FFFF, KIND_CON, 32'h8000_0000);
      send_item(CMD_GT, KIND_CON, 32'd0, KIND_CON, 32'hFFFF_FFFF);
      send_item(CMD_BOR, KIND_CON, 32'hF0F0_F0F0, KIND_CON, 32'h0F0F_0F0F);
      send_item(CMD_BXOR, KIND_CON, 32'hFFFF_FFFF, KIND_CON, 32'h1234_5678);
      send_item(CMD_BAND, KIND_CON, 32'hAAAA_AAAA, KIND_BOT, 0);
      send_item(CMD_BNOT, KIND_CON, 32'd0, KIND_TOP, 0);
      send_item(CMD_NEG, KIND_CON, 32'h8000_0000, KIND_BOT, 0);
      send_item(CMD_ADD, KIND_CON, 32'h7FFF_FFFF, KIND_CON, 32'd1);
      send_item(CMD_SUB, KIND_CON, 32'h8000_0000, KIND_CON, 32'd1);
      send_item(CMD_MUL, KIND_CON, 32'hFFFF_FFFF, KIND_CON, 32'h8000_0000);
      send_item(CMD_DIV, KIND_CON, 32'h8000_0000, KIND_CON, 32'hFFFF_FFFF);
      send_item(CMD_MOD, KIND_CON, 32'd17, KIND_CON, 32'd0);
      send_item(5'd31, KIND_CON, 32'd1, KIND_CON, 32'd1);

      // Hold off until every outstanding result item has come back.
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);

      // Random items in three idling phases.
      for (int i = 0; i < 1100; i++) begin
         if (i == 370) begin
            send_idle_pct = 74;
            recv_idle_pct = 23;
         end
         if (i == 740) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         cmd = ($urandom_range(29) == 0) ? 5'($urandom_range(31, 19)) : 5'($urandom_range(18));
         send_item(cmd, pick_kind(), pick_value(), pick_kind(), pick_value());
      end
      req_tvalid <= 1'b0;

      // Drain and let the pipeline settle.
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire
